@@ rtl/tte_pkg.sv @@
// Shared types, register indexes and score helpers of the transposition table engine.
package tte_pkg;

  localparam logic [7:0] REG_MATE_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_CONTEMPT_SCORE = 8'd1;
  localparam logic [7:0] REG_CURRENT_AGE    = 8'd2;
  localparam logic [7:0] REG_MAX_DEPTH      = 8'd3;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_PROBE = 1'b1;

  typedef struct packed {
    logic [14:0] mate_threshold;
    logic [14:0] contempt_score;
    logic [15:0] current_age;
    logic [7:0]  max_depth;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic               skip;
    logic [63:0]        key;
    logic [23:0]        move;
    logic signed [15:0] score;
    logic [7:0]         ply;
    logic [7:0]         depth;
    logic [7:0]         flag;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic               usable;
    logic               stored;
    logic [23:0]        move;
    logic signed [15:0] score;
    logic [7:0]         flag;
  } res_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/tte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tte_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tte_front.sv @@
// Front end: accepts items, applies the contempt rule and mate adjustment, and queues them.
module tte_front
  import tte_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               clearing,
  input  logic               push,
  output logic               full,
  input  logic               in_op,
  input  logic [63:0]        in_key,
  input  logic [23:0]        in_move_in,
  input  logic signed [15:0] in_score_in,
  input  logic [7:0]         in_ply,
  input  logic [7:0]         in_depth,
  input  logic [7:0]         in_flag_in,
  output logic               q_valid,
  output cmd_t               q_cmd,
  input  logic               q_pop
);

  cmd_t        q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        accept;
  cmd_t        cmd_in;
  logic signed [17:0] s18, m18, d18, adj, mag;

  assign full   = (cnt_r == 2'd2) || clearing;
  assign accept = push && !full;

  always_comb begin
    s18 = 18'(in_score_in);
    m18 = $signed({3'b000, cfg.mate_threshold});
    d18 = $signed({10'b0, in_depth});
    mag = (s18 < 18'sd0) ? -s18 : s18;
    if (s18 > m18) begin
      adj = s18 + d18;
    end else if (s18 < -m18) begin
      adj = s18 - d18;
    end else begin
      adj = s18;
    end
    cmd_in.op    = in_op;
    cmd_in.skip  = (in_op == OP_STORE) && (mag == $signed({3'b000, cfg.contempt_score}));
    cmd_in.key   = in_key;
    cmd_in.move  = in_move_in;
    // Probes carry the raw score; only stores are adjusted on the way in.
    cmd_in.score = (in_op == OP_STORE) ? sat16(adj) : in_score_in;
    cmd_in.ply   = in_ply;
    cmd_in.depth = in_depth;
    cmd_in.flag  = in_flag_in;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wp_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (accept) begin
        wp_r <= !wp_r;
      end
      if (q_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, accept} - {1'b0, q_pop};
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rp_r];

endmodule

@@ rtl/tte_back.sv @@
// Back end: clears the table, then reads a set, evaluates its ways and may write one back.
module tte_back
  import tte_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096,
  parameter int WAYS          = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  output logic clearing,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int ROWS   = TABLE_ENTRIES / WAYS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WAY_SH = $clog2(WAYS);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  function automatic logic [ROW_W-1:0] row_of(input logic [63:0] k);
    logic [63:0] t;
    t = (k >> WAY_SH) & 64'(ROWS - 1);
    return t[ROW_W-1:0];
  endfunction

  logic [1:0]       state_r, state_nxt;
  logic [ROW_W-1:0] clr_cnt_r, clr_cnt_nxt;
  cmd_t             cmd_r;
  logic [WAYS-1:0]  match_r, empty_r;
  logic [24:0]      cost_r [WAYS];

  logic [127:0]     rd_word [WAYS];
  logic [WAYS-1:0]  match_c, empty_c;
  logic [24:0]      cost_c [WAYS];

  logic [ROW_W-1:0] raddr, waddr;
  logic [127:0]     wdata;
  logic             wfire;
  logic [WAY_W-1:0] tgt;
  logic             done, is_match;
  logic [24:0]      lowest;
  logic [WAY_W-1:0] repl;
  logic [63:0]      tdata;
  logic signed [17:0] sc18, m18, d18, adj;

  assign clearing = (state_r == ST_CLEAR);
  assign raddr    = row_of((state_r == ST_IDLE) ? q_cmd.key : cmd_r.key);
  assign waddr    = clearing ? clr_cnt_r : row_of(cmd_r.key);

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic [7:0]  eage, eply;
    logic signed [16:0] diff;
    logic [15:0] adiff;
    logic [16:0] hi;
    logic        we_w;

    assign we_w = clearing || (wfire && (tgt == WAY_W'(w)));

    tte_ram #(.WIDTH(128), .DEPTH(ROWS)) u_ram (
      .clk   (clk),
      .we    (we_w),
      .waddr (waddr),
      .wdata (clearing ? 128'd0 : wdata),
      .raddr (raddr),
      .rdata (rd_word[w])
    );

    assign eage  = rd_word[w][47:40];
    assign eply  = rd_word[w][55:48];
    assign diff  = $signed({1'b0, cfg.current_age}) - $signed({9'b0, eage});
    assign adiff = (diff < 17'sd0) ? 16'(-diff) : diff[15:0];
    assign hi    = {9'b0, eage} + {1'b0, adiff[15:8], 8'b0};
    assign cost_c[w]  = {hi, 8'b0} + {17'b0, eply};
    assign match_c[w] = (rd_word[w][127:64] == cmd_r.key);
    assign empty_c[w] = (rd_word[w][127:64] == 64'd0);
  end

  // Walk the ways in order: the first way whose tag matches or that is empty wins,
  // else the cheapest way below the start bound, earlier ways keeping ties, else way 0.
  always_comb begin
    done     = 1'b0;
    is_match = 1'b0;
    lowest   = 25'(cfg.max_depth) + {1'b0, cfg.current_age, 8'b0};
    repl     = '0;
    tgt      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!done) begin
        if (match_r[w]) begin
          done     = 1'b1;
          is_match = 1'b1;
          tgt      = WAY_W'(w);
        end else if (empty_r[w]) begin
          done = 1'b1;
          tgt  = WAY_W'(w);
        end else if (cost_r[w] < lowest) begin
          lowest = cost_r[w];
          repl   = WAY_W'(w);
        end
      end
    end
    if (!done) begin
      tgt = repl;
    end
  end

  always_comb begin
    tdata = rd_word[tgt][63:0];
    sc18  = 18'($signed(tdata[15:0]));
    m18   = $signed({3'b000, cfg.mate_threshold});
    d18   = $signed({10'b0, cmd_r.depth});
    if (sc18 > m18) begin
      adj = sc18 - d18;
    end else if (sc18 < -m18) begin
      adj = sc18 + d18;
    end else begin
      adj = sc18;
    end

    res = '0;
    if (cmd_r.op == OP_STORE) begin
      res.stored = !cmd_r.skip;
      wdata = {cmd_r.key, cmd_r.flag, cmd_r.ply, cfg.current_age[7:0], cmd_r.move,
               cmd_r.score};
    end else begin
      wdata = {rd_word[tgt][127:64], tdata[63:48], cfg.current_age[7:0], tdata[39:0]};
      if (is_match) begin
        res.hit  = 1'b1;
        res.move = tdata[39:16];
        res.flag = tdata[63:56];
        if (tdata[55:48] >= cmd_r.ply) begin
          res.usable = 1'b1;
          res.score  = sat16(adj);
        end
      end
    end
  end

  assign res_valid = (state_r == ST_WRITE);
  assign wfire     = res_valid && res_ready &&
                     ((cmd_r.op == OP_STORE) ? !cmd_r.skip : is_match);
  assign q_pop     = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ROW_W'(1);
        if (clr_cnt_r == ROW_W'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (state_r == ST_EVAL) begin
      match_r <= match_c;
      empty_r <= empty_c;
      for (int w = 0; w < WAYS; w++) begin
        cost_r[w] <= cost_c[w];
      end
    end
  end

endmodule

@@ rtl/transposition_table_engine_core.sv @@
// Top level of the transposition table engine: configuration registers, front, back and result register.
// A 4-way set-associative table of search results, one RAM per way holding tag and data of
// each set in one row. After reset the engine clears the table one set per cycle; full stays
// high until it is done, while configuration writes are taken throughout. Each store or probe
// then passes in order through the back end's set read from the way RAMs, evaluation of tags
// and replacement costs, and write-back of one way and result; the back end takes the next
// item only after that result is accepted. Results wait in an output register until popped;
// configuration must be written only while no item is in flight; the block does not enforce it.
module transposition_table_engine_core
  import tte_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096,
  parameter int WAYS          = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic               in_op,
  input  logic [63:0]        in_key,
  input  logic [23:0]        in_move_in,
  input  logic signed [15:0] in_score_in,
  input  logic [7:0]         in_ply,
  input  logic [7:0]         in_depth,
  input  logic [7:0]         in_flag_in,
  output logic               empty,
  input  logic               pop,
  output logic               out_hit,
  output logic               out_usable,
  output logic               out_stored,
  output logic [23:0]        out_move_out,
  output logic signed [15:0] out_score_out,
  output logic [7:0]         out_flag_out
);

  cfg_t cfg_r;
  logic clearing, q_valid, q_pop, res_valid, res_ready;
  cmd_t q_cmd;
  res_t res, out_r;
  logic out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mate_threshold <= 15'd32000;
      cfg_r.contempt_score <= 15'd0;
      cfg_r.current_age    <= 16'd0;
      cfg_r.max_depth      <= 8'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MATE_THRESHOLD: cfg_r.mate_threshold <= cfg_data[14:0];
        REG_CONTEMPT_SCORE: cfg_r.contempt_score <= cfg_data[14:0];
        REG_CURRENT_AGE:    cfg_r.current_age    <= cfg_data;
        REG_MAX_DEPTH:      cfg_r.max_depth      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  tte_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .clearing    (clearing),
    .push        (push),
    .full        (full),
    .in_op       (in_op),
    .in_key      (in_key),
    .in_move_in  (in_move_in),
    .in_score_in (in_score_in),
    .in_ply      (in_ply),
    .in_depth    (in_depth),
    .in_flag_in  (in_flag_in),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  tte_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .WAYS(WAYS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The result register takes a new result whenever it is free or being emptied by a transfer.
  assign res_ready = !out_valid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign empty         = !out_valid_r;
  assign out_hit       = out_r.hit;
  assign out_usable    = out_r.usable;
  assign out_stored    = out_r.stored;
  assign out_move_out  = out_r.move;
  assign out_score_out = out_r.score;
  assign out_flag_out  = out_r.flag;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the transposition table engine: directed table, then random traffic.
module tb;
  import tte_pkg::*;

  localparam int ENTRIES   = 4096;
  localparam int NWAYS     = 4;
  localparam int LIMIT     = 400000;
  localparam int N_RANDOM  = 1000;
  localparam int N_DIRECT  = 22;

  typedef struct {
    logic               op;
    logic [63:0]        key;
    logic [23:0]        move;
    logic signed [15:0] score;
    logic [7:0]         ply;
    logic [7:0]         depth;
    logic [7:0]         flag;
    logic               known;
    res_t               want;
  } req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic in_op = 1'b0;
  logic [63:0] in_key = '0;
  logic [23:0] in_move_in = '0;
  logic signed [15:0] in_score_in = '0;
  logic [7:0] in_ply = '0, in_depth = '0, in_flag_in = '0;
  logic empty;
  logic pop = 1'b0;
  logic out_hit, out_usable, out_stored;
  logic [23:0] out_move_out;
  logic signed [15:0] out_score_out;
  logic [7:0] out_flag_out;

  transposition_table_engine_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Own copy of the table and registers.
  logic [63:0] tag_mem [ENTRIES];
  logic [63:0] data_mem [ENTRIES];
  cfg_t regs;

  res_t pending [$];
  int   errors = 0;
  int   cycles = 0;
  int   n_results = 0, n_hits = 0, n_stores = 0;
  bit   idle_en = 1'b0;
  int   hold_pop = 0;
  logic [63:0] keys_seen [$];

  function automatic logic signed [15:0] clip(int s);
    if (s > 32767) return 16'sd32767;
    if (s < -32767) return -16'sd32767;
    return s[15:0];
  endfunction

  function automatic res_t table_access(req_t r);
    res_t o;
    int sc, mag, mate, setb, slot, pick;
    int unsigned lowest, cost, eage, eply, diff;
    logic [63:0] d;
    o = '0;
    mate = regs.mate_threshold;
    setb = r.key[11:0] & ~(NWAYS - 1);
    sc = r.score;
    if (r.op == OP_STORE) begin
      mag = sc < 0 ? -sc : sc;
      if (mag == int'(regs.contempt_score)) return o;
      if (sc > mate) sc += r.depth;
      if (sc < -mate) sc -= r.depth;
      sc = clip(sc);
      o.stored = 1'b1;
      d = {r.flag, r.ply, regs.current_age[7:0], r.move, 16'(sc)};
      lowest = regs.max_depth + (int'(regs.current_age) << 8);
      pick = setb;
      for (int i = 0; i < NWAYS; i++) begin
        slot = setb + i;
        if (tag_mem[slot] == r.key) begin
          data_mem[slot] = d;
          return o;
        end
        if (tag_mem[slot] == 0) begin
          pick = slot;
          break;
        end
        eage = data_mem[slot][47:40];
        eply = data_mem[slot][55:48];
        diff = regs.current_age > eage ? regs.current_age - eage : eage - regs.current_age;
        cost = eply + ((eage + (diff & ~32'hff)) << 8);
        if (cost < lowest) begin
          lowest = cost;
          pick = slot;
        end
      end
      tag_mem[pick] = r.key;
      data_mem[pick] = d;
      return o;
    end
    for (int i = 0; i < NWAYS; i++) begin
      slot = setb + i;
      if (tag_mem[slot] == r.key) begin
        data_mem[slot][47:40] = regs.current_age[7:0];
        d = data_mem[slot];
        o.hit = 1'b1;
        o.move = d[39:16];
        o.flag = d[63:56];
        if (d[55:48] >= r.ply) begin
          sc = $signed(d[15:0]);
          if (sc > mate) sc -= r.depth;
          if (sc < -mate) sc += r.depth;
          o.usable = 1'b1;
          o.score = clip(sc);
        end
        return o;
      end
    end
    return o;
  endfunction

  // Result side: pops always, or at random once idle_en is set, plus long hold-offs on request.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (hold_pop > 0) begin
      hold_pop <= hold_pop - 1;
      pop <= 1'b0;
    end else begin
      pop <= !idle_en || ($urandom_range(99) >= 22);
    end
    if (rst_n && pop && !empty) begin
      res_t e;
      n_results <= n_results + 1;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0b stored=%0b", out_hit, out_stored);
      end else begin
        e = pending.pop_front();
        if ({out_hit, out_usable, out_stored, out_move_out, out_score_out, out_flag_out}
            !== e) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want h%0b u%0b s%0b mv %h sc %0d fl %h, got h%0b u%0b s%0b mv %h sc %0d fl %h",
                     e.hit, e.usable, e.stored, e.move, e.score, e.flag, out_hit, out_usable,
                     out_stored, out_move_out, out_score_out, out_flag_out);
        end
      end
    end
  end

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MATE_THRESHOLD: regs.mate_threshold = val[14:0];
      REG_CONTEMPT_SCORE: regs.contempt_score = val[14:0];
      REG_CURRENT_AGE:    regs.current_age = val;
      REG_MAX_DEPTH:      regs.max_depth = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sends one transfer; the expectation is queued at the accepting edge.
  task automatic send(req_t r);
    res_t e;
    while (idle_en && $urandom_range(99) < 22) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_op <= r.op;
    in_key <= r.key;
    in_move_in <= r.move;
    in_score_in <= r.score;
    in_ply <= r.ply;
    in_depth <= r.depth;
    in_flag_in <= r.flag;
    do @(posedge clk); while (full);
    e = table_access(r);
    if (r.known && e !== r.want) begin
      errors++;
      $display("directed row disagrees with the table model");
    end
    if (r.op == OP_STORE) n_stores++;
    else if (e.hit) n_hits++;
    pending.push_back(e);
  endtask

  function automatic req_t mk(logic op, logic [63:0] key, logic [23:0] mv, int sc,
                              int ply, int dp, int fl);
    req_t r;
    r.op = op; r.key = key; r.move = mv; r.score = sc[15:0];
    r.ply = ply[7:0]; r.depth = dp[7:0]; r.flag = fl[7:0];
    r.known = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic logic [63:0] draw_key();
    logic [63:0] k;
    int setb;
    k = {$urandom, $urandom};
    // Crowd eight sets so that replacement is exercised hard.
    if ($urandom_range(3) != 0) begin
      setb = $urandom_range(7) * NWAYS;
      k[11:0] = 12'(setb + $urandom_range(NWAYS - 1));
      k[63:12] = 52'($urandom_range(11));
    end
    if (keys_seen.size() != 0 && $urandom_range(2) == 0)
      k = keys_seen[$urandom_range(keys_seen.size() - 1)];
    return k;
  endfunction

  function automatic int rand_score();
    case ($urandom_range(5))
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(767) + 32000;
      2: return -int'($urandom_range(767) + 32000);
      3: return int'(regs.contempt_score) * ($urandom_range(1) ? 1 : -1);
      default: return $urandom_range(2000) - 1000;
    endcase
  endfunction

  initial begin
    req_t table_rows [N_DIRECT];
    req_t r;
    logic [63:0] kmax;
    kmax = '1;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_mem[i] = '0;
      data_mem[i] = '0;
    end
    regs = '{mate_threshold: 15'd32000, contempt_score: 15'd0, current_age: 16'd0,
             max_depth: 8'd128};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: probe on an empty table, extremes, mate scores, a zero key.
    table_rows[0] = mk(OP_PROBE, 64'h1234, 0, 0, 0, 0, 0);
    table_rows[0].known = 1'b1;
    table_rows[1] = mk(OP_STORE, 64'h10, 24'h123456, 0, 5, 0, 1);
    table_rows[1].known = 1'b1;
    table_rows[2] = mk(OP_STORE, 64'h10, 24'h123456, 100, 5, 0, 1);
    table_rows[2].known = 1'b1; table_rows[2].want.stored = 1'b1;
    table_rows[3] = mk(OP_PROBE, 64'h10, 0, 0, 5, 0, 0);
    table_rows[4] = mk(OP_PROBE, 64'h10, 0, 0, 255, 0, 0);
    table_rows[5] = mk(OP_STORE, kmax, 24'hffffff, 32767, 255, 255, 255);
    table_rows[6] = mk(OP_PROBE, kmax, 24'hffffff, 0, 0, 255, 255);
    table_rows[7] = mk(OP_STORE, 64'h8000_0000_0000_0ffc, 0, -32768, 0, 255, 0);
    table_rows[8] = mk(OP_PROBE, 64'h8000_0000_0000_0ffc, 0, 0, 0, 0, 0);
    table_rows[9] = mk(OP_STORE, 64'h20, 24'h000001, 32100, 3, 50, 2);
    table_rows[10] = mk(OP_PROBE, 64'h20, 0, 0, 2, 7, 0);
    table_rows[11] = mk(OP_STORE, 64'h1020, 24'h000002, -32100, 3, 50, 3);
    table_rows[12] = mk(OP_PROBE, 64'h1020, 0, 0, 3, 250, 0);
    table_rows[13] = mk(OP_STORE, 64'h2020, 24'h3, 1, 9, 0, 4);
    table_rows[14] = mk(OP_STORE, 64'h3020, 24'h4, 2, 1, 0, 5);
    table_rows[15] = mk(OP_STORE, 64'h4020, 24'h5, 3, 0, 0, 6);
    table_rows[16] = mk(OP_PROBE, 64'h1020, 0, 0, 0, 0, 0);
    table_rows[17] = mk(OP_STORE, 64'h0, 24'h777, -5, 4, 0, 7);
    table_rows[18] = mk(OP_PROBE, 64'h0, 0, 0, 0, 0, 0);
    table_rows[19] = mk(OP_PROBE, 64'h4, 0, 0, 0, 0, 0);
    table_rows[20] = mk(OP_STORE, 64'haaaa_5555_aaaa_5555, 24'haaaaaa, -32767, 170, 85, 170);
    table_rows[21] = mk(OP_PROBE, 64'haaaa_5555_aaaa_5555, 0, 0, 85, 170, 0);
    foreach (table_rows[i]) send(table_rows[i]);
    drain();

    // Random phases, each under a different register setting.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_CURRENT_AGE, 16'd3); write_reg(REG_CONTEMPT_SCORE, 16'd7); end
        1: begin write_reg(REG_MATE_THRESHOLD, 16'd0); write_reg(REG_MAX_DEPTH, 16'd0);
                 write_reg(REG_CURRENT_AGE, 16'hffff); end
        2: begin write_reg(REG_MATE_THRESHOLD, 16'h7fff); write_reg(REG_CONTEMPT_SCORE, 16'h7fff);
                 write_reg(REG_MAX_DEPTH, 16'd255); write_reg(REG_CURRENT_AGE, 16'd0); end
        3: begin write_reg(REG_MATE_THRESHOLD, 16'd100); write_reg(REG_CONTEMPT_SCORE, 16'd0);
                 write_reg(REG_CURRENT_AGE, 16'd300); end
        default: begin write_reg(REG_MATE_THRESHOLD, 16'd32000);
                 write_reg(REG_CURRENT_AGE, 16'd1000); write_reg(REG_MAX_DEPTH, 16'd128); end
      endcase
      cfg_valid <= 1'b0;
      idle_en = (ph != 0);
      // Long receiver hold-off so the input queue backs up.
      if (ph == 2) hold_pop = 300;
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        r = mk($urandom_range(1), draw_key(), $urandom_range(24'hffffff), rand_score(),
               $urandom_range(255), $urandom_range(255), $urandom_range(255));
        if ($urandom_range(1)) r.ply = $urandom_range(7);
        keys_seen.push_back(r.key);
        if (keys_seen.size() > 40) void'(keys_seen.pop_front());
        send(r);
        // Sender pause until everything is back.
        if (ph == 3 && n == 100) drain();
      end
      drain();
    end

    $display("covered %0d results, %0d stores and %0d probe hits over six register settings",
             n_results, n_stores, n_hits);
    $display("including a long result stall and a full drain mid-phase");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("mismatches: %0d", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
